[sv/occupancy_grid_ray_update_assert.svh]
// Assertion macros for the occupancy grid ray update block.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define OGRU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("occupancy grid ray update assertion failed");
`define OGRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("occupancy grid ray update assertion failed");
`else
`define OGRU_ASSERT_NOW(lbl, ante, cons)
`define OGRU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/ogru_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// occupancy grid ray update block. No dependencies.
`default_nettype none
package ogru_pkg;
	localparam int GRID_DIM = 256;
	localparam int LAYERS = 32;
	localparam int COORD_W = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam int DEPTH = GRID_DIM * GRID_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int CELL_W = 2;
	localparam int WORD_W = CELL_W + CELL_W * LAYERS;
	localparam int POS_W = 18;
	localparam int ERR_W = POS_W + 1;
	localparam int WALK_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [1:0] ACT_CAST = 2'd0;
	localparam logic [1:0] ACT_READ_PLANE = 2'd1;
	localparam logic [1:0] ACT_READ_VOXEL = 2'd2;

	localparam logic [CELL_W-1:0] CELL_UNKNOWN = 2'd0;
	localparam logic [CELL_W-1:0] CELL_FREE = 2'd1;
	localparam logic [CELL_W-1:0] CELL_OCC = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYERS_IN_USE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_LAYER = 2'd3;

	typedef struct packed {
		logic clear;
		logic load;
		logic visit;
		logic modify;
		logic qread;
		logic qcapture;
		logic set_left;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_of_grid;
		logic at_end;
	} status_t;
endpackage
`default_nettype wire

[sv/ogru_ctrl.sv]
// Controller state machine for the occupancy grid ray update block.
// Depends on ogru_pkg and the assertion macro header.
`default_nettype none
`include "occupancy_grid_ray_update_assert.svh"
module ogru_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        action,
	input  wire ogru_pkg::status_t status,
	output ogru_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_MODIFY = 3'd3;
	localparam logic [2:0] S_QUERY = 3'd4;
	localparam logic [2:0] S_QRESP = 3'd5;
	localparam logic [2:0] S_REPORT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_next;

	always_comb begin
		state_next = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (action == ogru_pkg::ACT_CAST) begin
						state_next = S_CHECK;
					end else if (action == ogru_pkg::ACT_READ_PLANE ||
							action == ogru_pkg::ACT_READ_VOXEL) begin
						state_next = S_QUERY;
					end else begin
						state_next = S_REPORT;
					end
				end
			end
			S_CHECK: begin
				if (status.out_of_grid) begin
					cmd.set_left = 1'b1;
					state_next = S_REPORT;
				end else begin
					cmd.visit = 1'b1;
					state_next = S_MODIFY;
				end
			end
			S_MODIFY: begin
				cmd.modify = 1'b1;
				state_next = status.at_end ? S_REPORT : S_CHECK;
			end
			S_QUERY: begin
				cmd.qread = 1'b1;
				state_next = S_QRESP;
			end
			S_QRESP: begin
				cmd.qcapture = 1'b1;
				state_next = S_REPORT;
			end
			S_REPORT: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_REPORT);

	`OGRU_ASSERT_NEXT(a_done_single, done, !done)
	`OGRU_ASSERT_NOW(a_modify_follows_check, state_q == S_MODIFY, $past(state_q) == S_CHECK)
	`OGRU_ASSERT_NOW(a_report_source, done, $past(state_q) == S_IDLE || $past(state_q) == S_CHECK || $past(state_q) == S_MODIFY || $past(state_q) == S_QRESP)
endmodule
`default_nettype wire

[sv/ogru_datapath.sv]
// Datapath of the occupancy grid ray update block: configuration registers,
// Bresenham stepper, cell memory with clearing pass, and result registers.
// Depends on ogru_pkg.
`default_nettype none
module ogru_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ogru_pkg::cmd_t                     cmd,
	output ogru_pkg::status_t                       status,
	input  wire logic                               cfg_we,
	input  wire logic [ogru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ogru_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic signed [15:0]                 start_x,
	input  wire logic signed [15:0]                 start_y,
	input  wire logic signed [15:0]                 end_x,
	input  wire logic signed [15:0]                 end_y,
	input  wire logic                               mark_endpoint,
	input  wire logic [7:0]                         query_x,
	input  wire logic [7:0]                         query_y,
	input  wire logic [4:0]                         query_layer,
	input  wire logic [1:0]                         action,
	output logic [ogru_pkg::WALK_W-1:0]             cells_walked,
	output logic                                    endpoint_reached,
	output logic                                    left_grid,
	output logic [ogru_pkg::CELL_W-1:0]             cell_state
);
	localparam int PW = ogru_pkg::POS_W;
	localparam int EW = ogru_pkg::ERR_W;
	localparam int AW = ogru_pkg::ADDR_W;
	localparam int CW = ogru_pkg::CELL_W;
	localparam int WW = ogru_pkg::WORD_W;

	logic [8:0] grid_width_q;
	logic [8:0] grid_height_q;
	logic [5:0] layers_q;
	logic [5:0] obstacle_q;

	logic signed [PW-1:0] x_q, y_q, x1_q, y1_q;
	logic signed [EW-1:0] dx_q, dy_q, err_q;
	logic sx_neg_q, sy_neg_q, mark_q;
	logic [AW-1:0] qaddr_q;
	logic [ogru_pkg::LAYER_W-1:0] qlayer_q;
	logic q_valid_q, q_voxel_q;
	logic [AW-1:0] clr_addr_q;

	logic [WW-1:0] mem [ogru_pkg::DEPTH];
	logic [WW-1:0] rd_data_q;
	logic [AW-1:0] rd_addr, wr_addr, walk_addr;
	logic [WW-1:0] wr_data, upd_word;
	logic wr_en;

	logic [WW-1:0] end_word;
	logic [CW-1:0] q_cell;
	logic [31:0] w_lim, h_lim, lay_lim;
	logic vox_on;
	logic signed [PW-1:0] x0_ext, y0_ext, x1_ext, y1_ext, ddx, ddy;
	logic signed [EW-1:0] adx, ady, e2, err_next;
	logic x_step, y_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= 9'd200;
			grid_height_q <= 9'd200;
			layers_q <= 6'd30;
			obstacle_q <= 6'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ogru_pkg::REG_GRID_WIDTH: grid_width_q <= cfg_data;
				ogru_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				ogru_pkg::REG_LAYERS_IN_USE: layers_q <= cfg_data[5:0];
				ogru_pkg::REG_OBSTACLE_LAYER: obstacle_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		w_lim = (32'(grid_width_q) > ogru_pkg::GRID_DIM) ? ogru_pkg::GRID_DIM
			: 32'(grid_width_q);
		h_lim = (32'(grid_height_q) > ogru_pkg::GRID_DIM) ? ogru_pkg::GRID_DIM
			: 32'(grid_height_q);
		lay_lim = (32'(layers_q) > ogru_pkg::LAYERS) ? ogru_pkg::LAYERS : 32'(layers_q);
		vox_on = (32'(obstacle_q) < lay_lim);
	end

	assign status.out_of_grid = x_q[PW-1] || y_q[PW-1] ||
		(x_q >= $signed(PW'(w_lim))) || (y_q >= $signed(PW'(h_lim)));
	assign status.at_end = (x_q == x1_q) && (y_q == y1_q);
	assign status.clear_last = (32'(clr_addr_q) == ogru_pkg::DEPTH - 1);

	// Setup of the Bresenham walk.
	always_comb begin
		x0_ext = PW'(start_x);
		y0_ext = PW'(start_y);
		x1_ext = PW'(end_x);
		y1_ext = PW'(end_y);
		ddx = x1_ext - x0_ext;
		ddy = y1_ext - y0_ext;
		adx = ddx[PW-1] ? -EW'(ddx) : EW'(ddx);
		ady = ddy[PW-1] ? -EW'(ddy) : EW'(ddy);
	end

	always_comb begin
		e2 = err_q <<< 1;
		x_step = (e2 > -dy_q);
		y_step = (e2 < dx_q);
		err_next = err_q - (x_step ? dy_q : EW'(0)) + (y_step ? dx_q : EW'(0));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x0_ext;
			y_q <= y0_ext;
			x1_q <= x1_ext;
			y1_q <= y1_ext;
			dx_q <= adx;
			dy_q <= ady;
			err_q <= adx - ady;
			sx_neg_q <= !(x0_ext < x1_ext);
			sy_neg_q <= !(y0_ext < y1_ext);
			mark_q <= mark_endpoint;
			qaddr_q <= AW'(32'(query_y) * ogru_pkg::GRID_DIM + 32'(query_x));
			qlayer_q <= ogru_pkg::LAYER_W'(query_layer);
			q_voxel_q <= (action == ogru_pkg::ACT_READ_VOXEL);
			q_valid_q <= (32'(query_x) < ogru_pkg::GRID_DIM) &&
				(32'(query_y) < ogru_pkg::GRID_DIM) &&
				((action != ogru_pkg::ACT_READ_VOXEL) ||
				(32'(query_layer) < ogru_pkg::LAYERS));
		end else if (cmd.modify && !status.at_end) begin
			err_q <= err_next;
			if (x_step) begin
				x_q <= sx_neg_q ? x_q - PW'(1) : x_q + PW'(1);
			end
			if (y_step) begin
				y_q <= sy_neg_q ? y_q - PW'(1) : y_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// A memory word holds the plane cell in its low bits and the voxel column above it.
	assign walk_addr = AW'(32'(y_q[ogru_pkg::COORD_W-1:0]) * ogru_pkg::GRID_DIM +
		32'(x_q[ogru_pkg::COORD_W-1:0]));
	assign rd_addr = cmd.qread ? qaddr_q : walk_addr;

	always_comb begin
		upd_word = rd_data_q;
		end_word = rd_data_q;
		if (rd_data_q[CW-1:0] != ogru_pkg::CELL_OCC) begin
			upd_word[CW-1:0] = ogru_pkg::CELL_FREE;
		end
		end_word[CW-1:0] = ogru_pkg::CELL_OCC;
		for (int l = 0; l < ogru_pkg::LAYERS; l++) begin
			if (vox_on && (32'(l) == 32'(obstacle_q)) &&
					(rd_data_q[CW + CW*l +: CW] == ogru_pkg::CELL_UNKNOWN)) begin
				upd_word[CW + CW*l +: CW] = ogru_pkg::CELL_FREE;
			end
			if (vox_on && (32'(l) <= 32'(obstacle_q))) begin
				end_word[CW + CW*l +: CW] = ogru_pkg::CELL_OCC;
			end
		end
	end

	always_comb begin
		if (cmd.clear) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en = cmd.modify && (!status.at_end || mark_q);
			wr_addr = walk_addr;
			wr_data = status.at_end ? end_word : upd_word;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		q_cell = rd_data_q[CW-1:0];
		if (q_voxel_q) begin
			q_cell = '0;
			for (int l = 0; l < ogru_pkg::LAYERS; l++) begin
				if (32'(l) == 32'(qlayer_q)) begin
					q_cell = rd_data_q[CW + CW*l +: CW];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cells_walked <= '0;
			endpoint_reached <= 1'b0;
			left_grid <= 1'b0;
			cell_state <= '0;
		end else begin
			if (cmd.visit && (cells_walked != '1)) begin
				cells_walked <= cells_walked + ogru_pkg::WALK_W'(1);
			end
			if (cmd.modify && status.at_end) begin
				endpoint_reached <= 1'b1;
			end
			if (cmd.set_left) begin
				left_grid <= 1'b1;
			end
			if (cmd.qcapture) begin
				cell_state <= q_valid_q ? q_cell : ogru_pkg::CELL_UNKNOWN;
			end
		end
	end
endmodule
`default_nettype wire

[sv/occupancy_grid_ray_update.sv]
// A read passes through the query and response states to done, and an unknown action goes
// straight to done; a ray alternates the check and modify states over each in-grid cell,
// one memory read-modify-write per cell, and ends at its endpoint or on leaving the grid.
// One item at a time; busy stays high through done, so the next start is taken in the cycle
// after done at the earliest. Reset runs a clearing pass over all GRID_DIM*GRID_DIM (65536)
// words with busy high; configuration writes are taken at any time. Results show with done.
`default_nettype none
module occupancy_grid_ray_update (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	output logic                                 done,
	input  wire logic [1:0]                      action,
	input  wire logic signed [15:0]              start_x,
	input  wire logic signed [15:0]              start_y,
	input  wire logic signed [15:0]              end_x,
	input  wire logic signed [15:0]              end_y,
	input  wire logic                            mark_endpoint,
	input  wire logic [7:0]                      query_x,
	input  wire logic [7:0]                      query_y,
	input  wire logic [4:0]                      query_layer,
	output logic [ogru_pkg::WALK_W-1:0]          cells_walked,
	output logic                                 endpoint_reached,
	output logic                                 left_grid,
	output logic [ogru_pkg::CELL_W-1:0]          cell_state,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ogru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ogru_pkg::CFG_DATA_W-1:0] cfg_data
);
	ogru_pkg::cmd_t cmd;
	ogru_pkg::status_t status;

	assign cfg_ready = 1'b1;

	ogru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ogru_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.start_x          (start_x),
		.start_y          (start_y),
		.end_x            (end_x),
		.end_y            (end_y),
		.mark_endpoint    (mark_endpoint),
		.query_x          (query_x),
		.query_y          (query_y),
		.query_layer      (query_layer),
		.action           (action),
		.cells_walked     (cells_walked),
		.endpoint_reached (endpoint_reached),
		.left_grid        (left_grid),
		.cell_state       (cell_state)
	);
endmodule
`default_nettype wire

[sim/occupancy_grid_ray_update_tb.sv]
// Self-checking testbench for the occupancy grid ray update block.
// A scoreboard class mirrors the plane and voxel stores to predict every result.
// Depends on ogru_pkg and occupancy_grid_ray_update.
`timescale 1ns / 1ps
`default_nettype none
module occupancy_grid_ray_update_tb;
	import ogru_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [1:0]         action;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic               mark_endpoint;
		logic [7:0]         query_x;
		logic [7:0]         query_y;
		logic [4:0]         query_layer;
	} ray_cmd_t;

	typedef struct {
		logic [WALK_W-1:0] cells_walked;
		logic              endpoint_reached;
		logic              left_grid;
		logic [CELL_W-1:0] cell_state;
	} ray_result_t;

	class occupancy_scoreboard;
		bit [CELL_W-1:0] plane_map [GRID_DIM*GRID_DIM];
		bit [CELL_W-1:0] voxel_store [int];
		bit [8:0] width_reg = 9'd200;
		bit [8:0] height_reg = 9'd200;
		bit [5:0] layers_reg = 6'd30;
		bit [5:0] obstacle_reg = 6'd5;
		ray_result_t pending_results[$];
		int failures = 0;

		function int eff_width();
			return (width_reg > GRID_DIM) ? GRID_DIM : int'(width_reg);
		endfunction

		function int eff_height();
			return (height_reg > GRID_DIM) ? GRID_DIM : int'(height_reg);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRID_WIDTH: width_reg = data;
				REG_GRID_HEIGHT: height_reg = data;
				REG_LAYERS_IN_USE: layers_reg = data[5:0];
				REG_OBSTACLE_LAYER: obstacle_reg = data[5:0];
				default: ;
			endcase
		endfunction

		function void predict_item(ray_cmd_t c);
			ray_result_t r;
			int x, y, x1, y1, dx, dy, sx, sy, err, e2, w, h, lay, pi, z, key;
			bit vox_on;
			r = '{default: '0};
			case (c.action)
				ACT_CAST: begin
					x = c.start_x;
					y = c.start_y;
					x1 = c.end_x;
					y1 = c.end_y;
					w = eff_width();
					h = eff_height();
					lay = (layers_reg > LAYERS) ? LAYERS : int'(layers_reg);
					vox_on = obstacle_reg < lay;
					dx = (x1 > x) ? x1 - x : x - x1;
					dy = (y1 > y) ? y1 - y : y - y1;
					sx = (x < x1) ? 1 : -1;
					sy = (y < y1) ? 1 : -1;
					err = dx - dy;
					forever begin
						if (x < 0 || x >= w || y < 0 || y >= h) begin
							r.left_grid = 1'b1;
							break;
						end
						if (r.cells_walked < 10'd1023) r.cells_walked++;
						pi = y * GRID_DIM + x;
						if (x == x1 && y == y1) begin
							r.endpoint_reached = 1'b1;
							if (c.mark_endpoint) begin
								plane_map[pi] = CELL_OCC;
								if (vox_on) begin
									for (z = 0; z <= obstacle_reg; z++)
										voxel_store[(z * GRID_DIM + y) * GRID_DIM + x] = CELL_OCC;
								end
							end
							break;
						end
						if (plane_map[pi] != CELL_OCC) plane_map[pi] = CELL_FREE;
						if (vox_on) begin
							key = (int'(obstacle_reg) * GRID_DIM + y) * GRID_DIM + x;
							if (!voxel_store.exists(key) || voxel_store[key] == CELL_UNKNOWN)
								voxel_store[key] = CELL_FREE;
						end
						e2 = 2 * err;
						if (e2 > -dy) begin
							err -= dy;
							x += sx;
						end
						if (e2 < dx) begin
							err += dx;
							y += sy;
						end
					end
				end
				ACT_READ_PLANE: r.cell_state = plane_map[int'(c.query_y) * GRID_DIM + int'(c.query_x)];
				ACT_READ_VOXEL: begin
					key = (int'(c.query_layer) * GRID_DIM + int'(c.query_y)) * GRID_DIM
						+ int'(c.query_x);
					if (voxel_store.exists(key)) r.cell_state = voxel_store[key];
				end
				default: ;
			endcase
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void note_failure(string what, logic [WALK_W-1:0] want, logic [WALK_W-1:0] got);
			failures++;
			if (failures <= 10)
				$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		endfunction

		function void check_result(logic [WALK_W-1:0] walked, logic reached, logic left,
				logic [CELL_W-1:0] state);
			ray_result_t want;
			if (pending_results.size() == 0) begin
				note_failure("result with no pending item", '0, '0);
				return;
			end
			want = pending_results.pop_front();
			if (walked !== want.cells_walked)
				note_failure("cells_walked", want.cells_walked, walked);
			if (reached !== want.endpoint_reached)
				note_failure("endpoint_reached", want.endpoint_reached, reached);
			if (left !== want.left_grid)
				note_failure("left_grid", want.left_grid, left);
			if (state !== want.cell_state)
				note_failure("cell_state", want.cell_state, state);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic [1:0] action;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic mark_endpoint;
	logic [7:0] query_x;
	logic [7:0] query_y;
	logic [4:0] query_layer;
	logic [WALK_W-1:0] cells_walked;
	logic endpoint_reached;
	logic left_grid;
	logic [CELL_W-1:0] cell_state;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	occupancy_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int last_end_x = 0;
	int last_end_y = 0;

	occupancy_grid_ray_update uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.action(action),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.mark_endpoint(mark_endpoint),
		.query_x(query_x),
		.query_y(query_y),
		.query_layer(query_layer),
		.cells_walked(cells_walked),
		.endpoint_reached(endpoint_reached),
		.left_grid(left_grid),
		.cell_state(cell_state),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(cells_walked, endpoint_reached, left_grid, cell_state);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("occupancy_grid_ray_update_tb NOT OK");
			$finish;
		end
	end

	function automatic ray_cmd_t make_cast(int x0, int y0, int x1, int y1, bit mark);
		ray_cmd_t c;
		c.action = ACT_CAST;
		c.start_x = 16'(x0);
		c.start_y = 16'(y0);
		c.end_x = 16'(x1);
		c.end_y = 16'(y1);
		c.mark_endpoint = mark;
		c.query_x = 8'($urandom);
		c.query_y = 8'($urandom);
		c.query_layer = 5'($urandom);
		return c;
	endfunction

	function automatic ray_cmd_t make_read(logic [1:0] act, int qx, int qy, int ql);
		ray_cmd_t c;
		c = make_cast($urandom, $urandom, $urandom, $urandom, 1'($urandom));
		c.action = act;
		c.query_x = 8'(qx);
		c.query_y = 8'(qy);
		c.query_layer = 5'(ql);
		return c;
	endfunction

	task automatic issue(input ray_cmd_t c, input bit idle_on);
		int roll;
		action <= c.action;
		start_x <= c.start_x;
		start_y <= c.start_y;
		end_x <= c.end_x;
		end_y <= c.end_y;
		mark_endpoint <= c.mark_endpoint;
		query_x <= c.query_x;
		query_y <= c.query_y;
		query_layer <= c.query_layer;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.predict_item(c);
		if (idle_on) begin
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				start <= 1'b0;
				while (sb.outstanding() != 0) @(posedge clk);
			end else if (roll < 30) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [8:0] w, input logic [8:0] h,
			input logic [8:0] lay, input logic [8:0] obs);
		logic [8:0] vals [4];
		drain();
		vals = '{w, h, lay, obs};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.apply_register(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count, input bit idle_on);
		ray_cmd_t c;
		int w_lim, h_lim, pick, x0, y0, obs;
		for (int i = 0; i < count; i++) begin
			w_lim = sb.eff_width();
			h_lim = sb.eff_height();
			obs = sb.obstacle_reg;
			x0 = (w_lim > 0) ? $urandom_range(0, w_lim - 1) : $urandom_range(0, 3);
			y0 = (h_lim > 0) ? $urandom_range(0, h_lim - 1) : $urandom_range(0, 3);
			c = make_cast($urandom, $urandom, $urandom, $urandom, 1'($urandom));
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				c = make_cast(x0, y0, x0 + $urandom_range(0, 80) - 40,
					y0 + $urandom_range(0, 80) - 40, $urandom_range(0, 4) != 0);
				last_end_x = c.end_x;
				last_end_y = c.end_y;
			end else if (pick < 53) begin
				c.action = ACT_CAST;
			end else if (pick < 60) begin
				c.start_x = 16'(x0);
				c.start_y = 16'(y0);
			end else if (pick < 78) begin
				c.action = ACT_READ_PLANE;
				if ($urandom_range(0, 1)) begin
					c.query_x = 8'(last_end_x);
					c.query_y = 8'(last_end_y);
				end else begin
					c.query_x = 8'(x0);
					c.query_y = 8'(y0);
				end
			end else if (pick < 95) begin
				c.action = ACT_READ_VOXEL;
				if ($urandom_range(0, 1)) begin
					c.query_x = 8'(last_end_x);
					c.query_y = 8'(last_end_y);
				end
				if (obs < LAYERS && $urandom_range(0, 1))
					c.query_layer = 5'($urandom_range(0, obs));
			end else begin
				c.action = ACT_NONE;
			end
			issue(c, idle_on);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_CAST;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		mark_endpoint <= 1'b0;
		query_x <= '0;
		query_y <= '0;
		query_layer <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		issue(make_read(ACT_READ_PLANE, 0, 0, 0), 1'b0);
		issue(make_read(ACT_READ_VOXEL, 255, 255, 31), 1'b0);
		issue(make_cast(0, 0, 10, 5, 1'b1), 1'b0);
		drain();
		issue(make_read(ACT_READ_PLANE, 10, 5, 0), 1'b0);
		issue(make_read(ACT_READ_PLANE, 4, 2, 0), 1'b0);
		issue(make_read(ACT_READ_VOXEL, 10, 5, 0), 1'b0);
		issue(make_read(ACT_READ_VOXEL, 10, 5, 5), 1'b0);
		issue(make_read(ACT_READ_VOXEL, 0, 0, 5), 1'b0);
		issue(make_cast(0, 0, 20, 10, 1'b0), 1'b0);
		issue(make_read(ACT_READ_PLANE, 10, 5, 0), 1'b0);
		issue(make_read(ACT_READ_PLANE, 20, 10, 0), 1'b0);
		issue(make_cast(20, 20, 20, 20, 1'b0), 1'b0);
		issue(make_cast(-1, 5, 10, 5, 1'b1), 1'b0);
		issue(make_cast(199, 199, 300, 300, 1'b1), 1'b0);
		issue(make_cast(-32768, -32768, 32767, 32767, 1'b1), 1'b0);
		issue(make_cast(32767, 32767, -32768, -32768, 1'b1), 1'b0);
		issue(make_cast(100, 100, -32768, 32767, 1'b1), 1'b0);
		issue(make_cast(50, 60, 50, 10, 1'b1), 1'b0);
		issue(make_cast(60, 50, 10, 50, 1'b1), 1'b0);
		issue(make_read(ACT_READ_PLANE, 255, 255, 0), 1'b0);
		issue(make_read(ACT_READ_VOXEL, 50, 10, 4), 1'b0);
		issue(make_read(ACT_NONE, 255, 255, 31), 1'b0);
		run_random(150, 1'b1);

		write_config(9'd256, 9'd256, 9'd32, {3'($urandom), 6'd31});
		run_random(200, 1'b1);
		write_config(9'd511, 9'd300, 9'h1FF, 9'h1FF);
		run_random(150, 1'b1);
		write_config(9'd0, 9'd256, 9'd32, 9'd0);
		run_random(40, 1'b1);
		write_config(9'd1, 9'd1, 9'd1, {3'($urandom), 6'd0});
		run_random(60, 1'b1);
		write_config(9'($urandom_range(1, 511)), 9'($urandom_range(0, 511)), 9'($urandom),
			{3'($urandom), 6'($urandom_range(0, 40))});
		run_random(200, 1'b1);
		write_config(9'd256, 9'd256, {3'($urandom), 6'd0}, {3'($urandom), 6'd7});
		run_random(40, 1'b0);
		write_config(9'd256, 9'd256, 9'd32, 9'd7);
		run_random(160, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.failures += sb.outstanding();
		end
		if (sb.failures == 0) begin
			$display("occupancy_grid_ray_update_tb OK");
		end else begin
			$display("occupancy_grid_ray_update_tb NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire
